// ----- rtl/utf8_stream_decoder_unit_macros.svh -----
// Assertion helpers shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8sd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8sd assertion failed");

`endif

// ----- rtl/u8sd_pkg.sv -----
`timescale 1ns / 1ps

package u8sd_pkg;

    typedef enum logic [2:0] {
        ST_CHAR       = 3'd0,
        ST_SUBST      = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_END        = 3'd3,
        ST_STOPPED    = 3'd4
    } status_t;

    typedef enum logic {
        REG_STOP_ON_ERROR = 1'b0,
        REG_OUTPUT_LIMIT  = 1'b1
    } reg_index_t;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned PADDR_W    = 3;
    localparam logic [CP_W-1:0] SUBST_CHAR = 21'h00003F;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
    } out_item_t;

    typedef struct packed {
        logic               stop_on_error;
        logic [COUNT_W-1:0] output_limit;
    } cfg_t;

    // Decoder result for the item in the input register.
    typedef struct packed {
        logic      has_result;
        out_item_t item;
    } dec_result_t;

endpackage

// ----- rtl/utf8_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// Channel   Signals                               Direction  Moves
// in        in_valid / in_ready / in_data         in         byte or end-of-stream mark
// out       out_valid / out_ready / out_data      out        code point and status
// apb       psel penable pwrite paddr pwdata ...  in/out     stop_on_error, output_limit
//
// One byte per clock sustained while the output is not stalled; a result passes through the
// input register, then decode logic into the result register, which drives out_valid.
// rst_n is asynchronous: decoder state clears, output_limit returns to 65535.
// A byte that yields no result retires even while the result register is stalled;
// only a byte with a result waits for out_ready.

module utf8_stream_decoder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [u8sd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  u8sd_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output u8sd_pkg::out_item_t          out_data
);
    import u8sd_pkg::*;

    cfg_t        cfg;
    logic        advance;
    logic        item_valid;
    in_item_t    item;
    logic        out_free;
    dec_result_t result;

    u8sd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    u8sd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    u8sd_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .result     (result)
    );

    u8sd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/u8sd_apb_regs.sv -----
`timescale 1ns / 1ps

module u8sd_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [u8sd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output u8sd_pkg::cfg_t                 cfg
);
    import u8sd_pkg::*;

    logic               stop_reg;
    logic               stop_next;
    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] limit_next;
    logic               wr_en;
    reg_index_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[2]);

    always_comb
    begin
        stop_next  = stop_reg;
        limit_next = limit_reg;
        if (wr_en)
        begin
            case (idx)
                REG_STOP_ON_ERROR: stop_next  = pwdata[0];
                REG_OUTPUT_LIMIT:  limit_next = pwdata[COUNT_W-1:0];
                default:           stop_next  = stop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg  <= 1'b0;
            limit_reg <= COUNT_MAX;
        end
        else
        begin
            stop_reg  <= stop_next;
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_STOP_ON_ERROR: prdata = {31'd0, stop_reg};
            REG_OUTPUT_LIMIT:  prdata = {{(32-COUNT_W){1'b0}}, limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.stop_on_error = stop_reg;
    assign cfg.output_limit  = limit_reg;

endmodule

// ----- rtl/u8sd_in_stage.sv -----
`timescale 1ns / 1ps

module u8sd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  u8sd_pkg::in_item_t in_data,
    input  logic               advance,
    output logic               item_valid,
    output u8sd_pkg::in_item_t item
);
    import u8sd_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;
    logic     load;

    // Register frees up in the same cycle its item retires.
    assign in_ready = !vld_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/u8sd_decode.sv -----
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_macros.svh"

module u8sd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8sd_pkg::cfg_t        cfg,
    input  logic                  item_valid,
    input  u8sd_pkg::in_item_t    item,
    input  logic                  out_free,
    output logic                  advance,
    output u8sd_pkg::dec_result_t result
);
    import u8sd_pkg::*;

    logic [1:0]         pending_reg;
    logic [1:0]         pending_next;
    logic [CP_W-1:0]    partial_reg;
    logic [CP_W-1:0]    partial_next;
    logic               bad_reg;
    logic               bad_next;
    logic               halted_reg;
    logic               halted_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [7:0]         b;
    logic [1:0]         pend_dec;
    logic [CP_W-1:0]    cont_bits;
    logic [CP_W-1:0]    merged;
    logic               bad_seen;
    logic               has;
    logic [CP_W-1:0]    cp;
    status_t            st;

    assign b = item.data_byte;
    assign pend_dec = pending_reg - 2'd1;
    assign bad_seen = bad_reg || (b[7:6] != 2'b10);

    // Place the six payload bits of a continuation byte.
    always_comb
    begin
        case (pend_dec)
            2'd0:    cont_bits = {15'd0, b[5:0]};
            2'd1:    cont_bits = {9'd0, b[5:0], 6'd0};
            2'd2:    cont_bits = {3'd0, b[5:0], 12'd0};
            default: cont_bits = '0;
        endcase
    end

    assign merged = partial_reg | cont_bits;

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        bad_next     = bad_reg;
        halted_next  = halted_reg;
        has          = 1'b0;
        cp           = '0;
        st           = ST_CHAR;

        if (item.end_of_stream)
        begin
            has          = 1'b1;
            st           = (pending_reg != 2'd0) ? ST_INCOMPLETE : ST_END;
            pending_next = 2'd0;
            partial_next = '0;
            bad_next     = 1'b0;
            halted_next  = 1'b0;
        end
        else if (halted_reg)
        begin
            has = 1'b0;
        end
        else if (pending_reg != 2'd0)
        begin
            pending_next = pend_dec;
            if (pend_dec != 2'd0)
            begin
                partial_next = merged;
                bad_next     = bad_seen;
            end
            else
            begin
                partial_next = '0;
                bad_next     = 1'b0;
                has          = 1'b1;
                if (!bad_seen)
                begin
                    cp = merged;
                    st = ST_CHAR;
                end
                else if (cfg.stop_on_error)
                begin
                    halted_next = 1'b1;
                    st          = ST_STOPPED;
                end
                else
                begin
                    cp = SUBST_CHAR;
                    st = ST_SUBST;
                end
            end
        end
        else if (cfg.stop_on_error && (count_reg >= cfg.output_limit))
        begin
            has = 1'b0;
        end
        else
        begin
            bad_next = 1'b0;
            case (b) inside
                [8'h00:8'h7F]:
                begin
                    has = 1'b1;
                    cp  = {13'd0, b};
                end
                [8'hC0:8'hDF]:
                begin
                    pending_next = 2'd1;
                    partial_next = {10'd0, b[4:0], 6'd0};
                end
                [8'hE0:8'hEF]:
                begin
                    pending_next = 2'd2;
                    partial_next = {5'd0, b[3:0], 12'd0};
                end
                [8'hF0:8'hF7]:
                begin
                    pending_next = 2'd3;
                    partial_next = {b[2:0], 18'd0};
                end
                [8'hF8:8'hFF]:
                begin
                    has = 1'b1;
                    if (cfg.stop_on_error)
                    begin
                        halted_next = 1'b1;
                        st          = ST_STOPPED;
                    end
                    else
                    begin
                        cp = SUBST_CHAR;
                        st = ST_SUBST;
                    end
                end
                default:
                begin
                    // stray continuation byte: skipped when stopping on error
                    has = !cfg.stop_on_error;
                    cp  = SUBST_CHAR;
                    st  = ST_SUBST;
                end
            endcase
        end
    end

    always_comb
    begin
        if (item.end_of_stream)
        begin
            count_next = '0;
        end
        else if (has && (st == ST_CHAR || st == ST_SUBST) && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Items without a result retire even while the output register is held.
    assign advance = item_valid && (!has || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            bad_reg     <= 1'b0;
            halted_reg  <= 1'b0;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            bad_reg     <= bad_next;
            halted_reg  <= halted_next;
            count_reg   <= count_next;
        end
    end

    assign result.has_result      = has;
    assign result.item.code_point = cp;
    assign result.item.status     = st;

    `U8SD_ASSERT_IMPL(a_halt_no_pending, clk, rst_n, halted_reg, pending_reg == 2'd0)
    `U8SD_ASSERT_IMPL(a_bad_in_sequence, clk, rst_n, bad_reg, pending_reg != 2'd0)
    `U8SD_ASSERT_IMPL(a_halted_silent, clk, rst_n,
        item_valid && halted_reg && !item.end_of_stream, !has)
    `U8SD_ASSERT_NEXT(a_count_monotonic, clk, rst_n,
        advance && !item.end_of_stream, count_reg >= $past(count_reg))

endmodule

// ----- rtl/u8sd_out_stage.sv -----
`timescale 1ns / 1ps

module u8sd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  u8sd_pkg::dec_result_t result,
    output logic                  out_free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8sd_pkg::out_item_t   out_data
);
    import u8sd_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    out_item_t data_reg;
    logic      load;

    assign out_free = !vld_reg || out_ready;
    assign load     = advance && result.has_result;

    always_comb
    begin
        vld_next = vld_reg;
        if (out_free)
        begin
            vld_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.item;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ----- verif/utf8_stream_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;

    import u8sd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          NUM_PHASES  = 7;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_index_t  idx;
        logic [31:0] val;
        in_item_t    item;
        out_item_t   exp;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;

    // Decoder shadow state and register copy
    logic [1:0]          pend_cnt = '0;
    logic [CP_W-1:0]     cp_accum = '0;
    bit                  bad_cont = 1'b0;
    bit                  dec_halted = 1'b0;
    logic [COUNT_W-1:0]  char_count = '0;
    bit                  cfg_stop = 1'b0;
    logic [COUNT_W-1:0]  cfg_limit = COUNT_MAX;

    out_item_t           decoded_q[$];
    out_item_t           want;
    in_item_t            burst_q[$];
    row_t                dir_rows[$];

    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  errors = 0;
    int unsigned         cycle_cnt = 0;

    // stop mode, output limit (-1: random limit, small in stop mode), sender idle, receiver stall, quota
    int phase_stop[NUM_PHASES]  = '{0, 1, 1, 0, 1, 1, 0};
    int phase_limit[NUM_PHASES] = '{65535, 65535, 3, 0, 0, -1, -1};
    int phase_idle[NUM_PHASES]  = '{0, 84, 0, 6, 0, 6, 84};
    int phase_stall[NUM_PHASES] = '{0, 0, 84, 6, 0, 6, 84};
    int phase_quota[NUM_PHASES] = '{150, 120, 120, 120, 15, 120, 105};

    utf8_stream_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Output side: every result transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got cp=%h status=%0d",
                         $time, out_data.code_point, out_data.status);
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_data.code_point !== want.code_point)
                begin
                    $display("%0t: code_point mismatch: expected %h, got %h",
                             $time, want.code_point, out_data.code_point);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    function automatic out_item_t count_result(logic [CP_W-1:0] cp, status_t st);
        out_item_t r;
        r.code_point = cp;
        r.status = st;
        if ((st == ST_CHAR || st == ST_SUBST) && char_count != COUNT_MAX)
            char_count = char_count + 1'b1;
        return r;
    endfunction

    function automatic out_item_t error_result();
        if (cfg_stop)
        begin
            dec_halted = 1'b1;
            return count_result('0, ST_STOPPED);
        end
        return count_result(SUBST_CHAR, ST_SUBST);
    endfunction

    // Dropped bytes (halted, over the limit, or stray in stop mode) give no result
    function automatic void decode_step(input in_item_t it, output bit has,
                                        output out_item_t res);
        logic [7:0] b;
        b = it.data_byte;
        has = 1'b0;
        res = '0;
        if (it.end_of_stream)
        begin
            res.code_point = '0;
            res.status = (pend_cnt != 0) ? ST_INCOMPLETE : ST_END;
            has = 1'b1;
            pend_cnt = '0;
            cp_accum = '0;
            bad_cont = 1'b0;
            dec_halted = 1'b0;
            char_count = '0;
            return;
        end
        if (dec_halted)
            return;
        if (pend_cnt != 0)
        begin
            if (b[7:6] != 2'b10)
                bad_cont = 1'b1;
            pend_cnt = pend_cnt - 1'b1;
            cp_accum = cp_accum | (CP_W'(b[5:0]) << (6 * pend_cnt));
            if (pend_cnt != 0)
                return;
            has = 1'b1;
            if (bad_cont)
            begin
                bad_cont = 1'b0;
                cp_accum = '0;
                res = error_result();
                return;
            end
            res = count_result(cp_accum, ST_CHAR);
            cp_accum = '0;
            return;
        end
        if (cfg_stop && char_count >= cfg_limit)
            return;
        bad_cont = 1'b0;
        if (!b[7])
        begin
            has = 1'b1;
            res = count_result(CP_W'(b), ST_CHAR);
        end
        else if (b[7:5] == 3'b110)
        begin
            pend_cnt = 2'd1;
            cp_accum = CP_W'(b[4:0]) << 6;
        end
        else if (b[7:4] == 4'b1110)
        begin
            pend_cnt = 2'd2;
            cp_accum = CP_W'(b[3:0]) << 12;
        end
        else if (b[7:3] == 5'b11110)
        begin
            pend_cnt = 2'd3;
            cp_accum = CP_W'(b[2:0]) << 18;
        end
        else if (b[7:3] == 5'b11111)
        begin
            has = 1'b1;
            res = error_result();
        end
        else if (!cfg_stop)
        begin
            has = 1'b1;
            res = count_result(SUBST_CHAR, ST_SUBST);
        end
    endfunction

    function automatic row_t byte_row(logic [7:0] b);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.data_byte = b;
        return r;
    endfunction

    function automatic row_t typed_row(logic [7:0] b, logic eos, logic [CP_W-1:0] cp,
                                       status_t st);
        row_t r;
        r = '0;
        r.kind = ROW_TYPED;
        r.item.data_byte = b;
        r.item.end_of_stream = eos;
        r.exp.code_point = cp;
        r.exp.status = st;
        return r;
    endfunction

    function automatic row_t cfg_row(reg_index_t idx, logic [31:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic in_item_t byte_item(logic [7:0] b);
        in_item_t it;
        it.data_byte = b;
        it.end_of_stream = 1'b0;
        return it;
    endfunction

    function automatic in_item_t eos_item();
        in_item_t it;
        it.data_byte = 8'($urandom_range(255));
        it.end_of_stream = 1'b1;
        return it;
    endfunction

    function automatic logic [7:0] lead_byte(int n);
        case (n)
            2: return {3'b110, 5'($urandom_range(31))};
            3: return {4'b1110, 4'($urandom_range(15))};
            default: return {5'b11110, 3'($urandom_range(7))};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    // One random burst: mostly well-formed sequences, some broken ones and noise
    function automatic void build_burst();
        int r;
        int n;
        int k;
        logic [7:0] b;
        burst_q.delete();
        r = $urandom_range(99);
        if (r < 20)
            burst_q.push_back(byte_item(8'($urandom_range(127))));
        else if (r < 75)
        begin
            if (r < 40)
                n = 2;
            else if (r < 55)
                n = 3;
            else if (r < 70)
                n = 4;
            else
                n = $urandom_range(2, 4);
            burst_q.push_back(byte_item(lead_byte(n)));
            for (int i = 1; i < n; i++)
                burst_q.push_back(byte_item(cont_byte()));
            if (r >= 70)
            begin
                // corrupt one continuation byte
                k = $urandom_range(1, n - 1);
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                burst_q[k].data_byte = b;
            end
        end
        else if (r < 80)
        begin
            // sequence cut short by end of stream
            n = $urandom_range(2, 4);
            k = $urandom_range(0, n - 2);
            burst_q.push_back(byte_item(lead_byte(n)));
            for (int i = 0; i < k; i++)
                burst_q.push_back(byte_item(cont_byte()));
            burst_q.push_back(eos_item());
        end
        else if (r < 85)
            burst_q.push_back(byte_item(cont_byte()));
        else if (r < 89)
            burst_q.push_back(byte_item({5'b11111, 3'($urandom_range(7))}));
        else if (r < 94)
            burst_q.push_back(byte_item(8'($urandom_range(255))));
        else
            burst_q.push_back(eos_item());
    endfunction

    task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_STOP_ON_ERROR)
            cfg_stop = val[0];
        else
            cfg_limit = val[COUNT_W-1:0];
    endtask

    // Quiet the sender, drain results, then cover the two-stage pipeline for no-result bytes
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_item(input in_item_t it, input bit typed, input out_item_t typed_exp);
        bit has;
        out_item_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_step(it, has, res);
        if (typed)
            decoded_q.push_back(typed_exp);
        else if (has)
            decoded_q.push_back(res);
    endtask

    initial
    begin
        bit paused;
        int sent_n;
        int lim;

        dir_rows.push_back(typed_row(8'h00, 1'b0, 21'h0, ST_CHAR));
        dir_rows.push_back(typed_row(8'h7F, 1'b0, 21'h7F, ST_CHAR));
        // largest 21-bit code point
        dir_rows.push_back(byte_row(8'hF7));
        dir_rows.push_back(byte_row(8'hBF));
        dir_rows.push_back(byte_row(8'hBF));
        dir_rows.push_back(byte_row(8'hBF));
        dir_rows.push_back(typed_row(8'hFF, 1'b0, SUBST_CHAR, ST_SUBST));
        dir_rows.push_back(typed_row(8'h80, 1'b0, SUBST_CHAR, ST_SUBST));
        // bad continuation in the middle of a three-byte sequence
        dir_rows.push_back(byte_row(8'hE2));
        dir_rows.push_back(byte_row(8'h41));
        dir_rows.push_back(byte_row(8'h82));
        dir_rows.push_back(byte_row(8'hE2));
        dir_rows.push_back(typed_row(8'h5A, 1'b1, 21'h0, ST_INCOMPLETE));
        dir_rows.push_back(cfg_row(REG_STOP_ON_ERROR, 32'd1));
        dir_rows.push_back(typed_row(8'hF8, 1'b0, 21'h0, ST_STOPPED));
        dir_rows.push_back(byte_row(8'h41));
        dir_rows.push_back(typed_row(8'h00, 1'b1, 21'h0, ST_END));
        dir_rows.push_back(byte_row(8'hBF));
        dir_rows.push_back(cfg_row(REG_OUTPUT_LIMIT, 32'd1));
        dir_rows.push_back(typed_row(8'h41, 1'b0, 21'h41, ST_CHAR));
        dir_rows.push_back(byte_row(8'h42));
        dir_rows.push_back(typed_row(8'hA5, 1'b1, 21'h0, ST_END));
        // limit lowered while a sequence is open: it still completes
        dir_rows.push_back(byte_row(8'hC3));
        dir_rows.push_back(cfg_row(REG_OUTPUT_LIMIT, 32'd0));
        dir_rows.push_back(byte_row(8'hA9));
        dir_rows.push_back(cfg_row(REG_OUTPUT_LIMIT, 32'(COUNT_MAX)));
        dir_rows.push_back(byte_row(8'hC3));
        dir_rows.push_back(typed_row(8'h28, 1'b0, 21'h0, ST_STOPPED));
        dir_rows.push_back(typed_row(8'h00, 1'b1, 21'h0, ST_END));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                apb_write(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                run_item(dir_rows[i].item, dir_rows[i].kind == ROW_TYPED, dir_rows[i].exp);
        end

        paused = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            lim = phase_limit[p];
            if (lim < 0)
                lim = (phase_stop[p] != 0) ? $urandom_range(1, 40) : $urandom_range(0, 65535);
            apb_write(REG_STOP_ON_ERROR, 32'(phase_stop[p]));
            apb_write(REG_OUTPUT_LIMIT, 32'(lim));
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            sent_n = 0;
            while (sent_n < phase_quota[p])
            begin
                build_burst();
                foreach (burst_q[i])
                begin
                    run_item(burst_q[i], 1'b0, '0);
                    sent_n++;
                end
                // hold off the sender until the output side has caught up
                if (p == 1 && !paused && sent_n >= 60)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        in_valid <= 1'b0;
        stall_pct = 0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && decoded_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
